// ----- rtl/core/c3x3_pkg.sv -----
package c3x3_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int PIX_W   = 16;
  localparam int COEF_W  = 16;
  localparam int KROW_W  = 48;
  localparam int ACC_W   = 35;
  localparam int POS_W   = 10;
  localparam int CFG_W   = 48;
  localparam int DIM_W   = 11;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KTOP   = 3'd2,
    REG_KMID   = 3'd3,
    REG_KBOT   = 3'd4
  } reg_idx_t;

  // One classified item: window columns and what to emit.
  typedef struct packed {
    logic [8:0][PIX_W-1:0] win;
    logic                  emit_a;
    logic                  emit_b;
    logic [POS_W-1:0]      row;
    logic [POS_W-1:0]      col_a;
    logic [POS_W-1:0]      col_b;
    logic                  eof_b;
  } job_t;

  typedef struct packed {
    logic [ACC_W-1:0] value;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
    logic             eof;
  } res_t;

endpackage

// ----- rtl/core/c3x3_front.sv -----
module c3x3_front #(
  parameter int MAX_WIDTH  = c3x3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = c3x3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_geom,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0] height,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [c3x3_pkg::PIX_W-1:0]     in_pixel,
  output logic                           job_valid,
  input  logic                           job_ready,
  output c3x3_pkg::job_t                 job
);
  import c3x3_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);

  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];

  // Stage 1: address the line stores.
  logic            s1_v_r;
  logic [CW-1:0]   s1_c_r;
  logic [HW-1:0]   s1_r_r;
  logic [PIX_W-1:0] s1_p_r;
  logic [PIX_W-1:0] rd_new_r;
  logic [PIX_W-1:0] older_rd_r;
  logic            byp_r;
  logic [PIX_W-1:0] byp_d_r;
  logic [CW-1:0]   col_r, col_nxt;
  logic [HW-1:0]   row_r, row_nxt;
  logic [8:0][PIX_W-1:0] win_r, win_nxt;
  logic            job_v_r;
  job_t            job_r, job_nxt;
  logic            adv, acc;
  logic [CW-1:0]   c_eff;
  logic [HW-1:0]   r_eff;
  logic [PIX_W-1:0] p_eff;
  logic [PIX_W-1:0] top, mid;
  logic            last_col;
  logic [WW-1:0]   wm1;

  assign adv = !job_v_r || job_ready;
  assign in_ready = adv;
  assign acc = in_valid && in_ready;
  assign wm1 = width - WW'(1);

  always_comb begin
    c_eff = ({1'b0, col_r} >= (CW+1)'(width)) ? '0 : col_r;
    r_eff = (row_r > height) ? '0 : row_r;
    p_eff = (r_eff < height && !in_action) ? in_pixel : '0;
    last_col = (WW'(c_eff) + WW'(1) >= width);
    col_nxt = last_col ? '0 : c_eff + CW'(1);
    row_nxt = last_col ? ((r_eff >= height) ? '0 : r_eff + HW'(1)) : r_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_geom) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Reading stale memory: rows above the image are masked by row position.
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_new_r <= newer_mem[c_eff];
      newer_mem[c_eff] <= p_eff;
      s1_c_r <= c_eff;
      s1_r_r <= r_eff;
      s1_p_r <= p_eff;
    end
  end

  // The older store is written one stage late, so a read of the column that
  // is being written in the same cycle takes the pending data instead.
  always_ff @(posedge clk) begin
    if (acc) begin
      older_rd_r <= older_mem[c_eff];
      byp_r      <= s1_v_r && (s1_c_r == c_eff);
      byp_d_r    <= rd_new_r;
    end
    if (adv && s1_v_r) older_mem[s1_c_r] <= rd_new_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= acc;
  end

  // Stage 2: build the window and the job.
  always_comb begin
    top = (s1_r_r >= HW'(2)) ? (byp_r ? byp_d_r : older_rd_r) : '0;
    mid = (s1_r_r >= HW'(1)) ? rd_new_r : '0;
    win_nxt = win_r;
    if (s1_c_r == '0) win_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      win_nxt[i*3+0] = win_nxt[i*3+1];
      win_nxt[i*3+1] = win_nxt[i*3+2];
    end
    win_nxt[2] = top;
    win_nxt[5] = mid;
    win_nxt[8] = s1_p_r;
    job_nxt.win    = win_nxt;
    job_nxt.emit_a = (s1_r_r != '0) && (s1_c_r != '0);
    job_nxt.emit_b = (s1_r_r != '0) && (WW'(s1_c_r) == wm1);
    job_nxt.row    = POS_W'(s1_r_r - HW'(1));
    job_nxt.col_a  = POS_W'(s1_c_r - CW'(1));
    job_nxt.col_b  = POS_W'(wm1);
    job_nxt.eof_b  = (s1_r_r == height);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      job_v_r <= 1'b0;
    end else if (adv) begin
      if (s1_v_r) win_r <= win_nxt;
      job_v_r <= s1_v_r && (job_nxt.emit_a || job_nxt.emit_b);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) job_r <= job_nxt;
  end

  assign job_valid = job_v_r;
  assign job       = job_r;

  assert property (@(posedge clk) disable iff (!rst_n) job_v_r && !job_ready |=> job_v_r)
    else $error("job dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
                   job_v_r |-> job_r.emit_a || job_r.emit_b)
    else $error("job with nothing to emit");
  assert property (@(posedge clk) disable iff (!rst_n) acc |-> adv)
    else $error("transfer taken while stalled");
endmodule

// ----- rtl/core/c3x3_back.sv -----
module c3x3_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [2:0][c3x3_pkg::KROW_W-1:0] krows,
  input  logic                          job_valid,
  output logic                          job_ready,
  input  c3x3_pkg::job_t                job,
  output logic                          res_valid,
  input  logic                          res_ready,
  output c3x3_pkg::res_t                res
);
  import c3x3_pkg::*;

  localparam int PROD_W = PIX_W + COEF_W;

  // Queue slot: one job, emitted in one or two results.
  logic  q_v_r, q_v_nxt;
  job_t  q_r;
  logic  phase_r, phase_nxt;
  logic  m_v_r;
  logic [8:0][PROD_W-1:0] prod_r;
  res_t  m_r, m_nxt;
  logic  o_v_r;
  res_t  o_r, o_nxt;
  logic  issue, m_adv, o_adv;
  logic  second;
  logic [ACC_W-1:0] sum;

  assign o_adv  = !o_v_r || res_ready;
  assign m_adv  = !m_v_r || o_adv;
  assign second = phase_r || !q_r.emit_a;
  assign issue  = q_v_r && m_adv;
  assign job_ready = !q_v_r || (issue && (second || !q_r.emit_b));

  always_comb begin
    phase_nxt = phase_r;
    if (issue) phase_nxt = !(second || !q_r.emit_b);
    q_v_nxt = q_v_r;
    if (job_ready) q_v_nxt = job_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r   <= 1'b0;
      phase_r <= 1'b0;
      m_v_r   <= 1'b0;
      o_v_r   <= 1'b0;
    end else begin
      q_v_r   <= q_v_nxt;
      phase_r <= job_ready ? 1'b0 : phase_nxt;
      if (m_adv) m_v_r <= issue;
      if (o_adv) o_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready) q_r <= job;
  end

  // Multiply stage. Center column 1 for the first result, 2 for the second.
  always_comb begin
    m_nxt.row  = q_r.row;
    m_nxt.col  = second ? q_r.col_b : q_r.col_a;
    m_nxt.last = second || !q_r.emit_b;
    m_nxt.eof  = second && q_r.eof_b;
    m_nxt.value = '0;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      m_r <= m_nxt;
      for (int kr = 0; kr < 3; kr++) begin
        for (int kc = 0; kc < 3; kc++) begin
          if (second) begin
            if (kc < 2)
              prod_r[kr*3+kc] <= $signed(q_r.win[kr*3+kc+1])
                * $signed(krows[kr][kc*COEF_W +: COEF_W]);
            else
              prod_r[kr*3+kc] <= '0;
          end else begin
            prod_r[kr*3+kc] <= $signed(q_r.win[kr*3+kc])
              * $signed(krows[kr][kc*COEF_W +: COEF_W]);
          end
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < 9; i++) sum = sum + ACC_W'($signed(prod_r[i]));
    o_nxt = m_r;
    o_nxt.value = sum;
  end

  always_ff @(posedge clk) begin
    if (o_adv && m_v_r) o_r <= o_nxt;
  end

  assign res_valid = o_v_r;
  assign res       = o_r;

  assert property (@(posedge clk) disable iff (!rst_n) o_v_r && !res_ready |=> o_v_r)
    else $error("result lost under stall");
  assert property (@(posedge clk) disable iff (!rst_n) phase_r |-> q_v_r)
    else $error("second phase without a job");
  assert property (@(posedge clk) disable iff (!rst_n)
                   issue && q_r.emit_b && !second |=> phase_r || !rst_n)
    else $error("second result skipped");
endmodule

// ----- rtl/core/conv3x3_zero_padded_filter.sv -----
// Stages: line store, window, job queue, multiply, output register. Throughput:
// one item per cycle while the output is not stalled; an item at the last column
// of a row after the first emits two results (one if the width is 1) and holds the
// input while the multiply stage issues the second. Reset: synchronous active low;
// counters, window, handshakes clear; geometry 640x480, kernel centre tap 256.
module conv3x3_zero_padded_filter #(
  parameter int MAX_WIDTH  = c3x3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = c3x3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [c3x3_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic signed [c3x3_pkg::PIX_W-1:0] in_pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [c3x3_pkg::ACC_W-1:0] out_filtered_value,
  output logic [c3x3_pkg::POS_W-1:0]    out_row,
  output logic [c3x3_pkg::POS_W-1:0]    out_col,
  output logic                          out_last_of_run,
  output logic                          out_end_of_frame
);
  import c3x3_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);

  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;
  logic [2:0][KROW_W-1:0] krows_r;
  logic [DIM_W-1:0] dim;
  logic cfg_geom;
  logic job_valid, job_ready;
  job_t job;
  res_t res;

  assign dim = cfg_data[DIM_W-1:0];
  assign cfg_geom = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'((640 > MAX_WIDTH) ? MAX_WIDTH : 640);
      height_r <= HW'((480 > MAX_HEIGHT) ? MAX_HEIGHT : 480);
      krows_r  <= {KROW_W'(0), KROW_W'(48'h1000000), KROW_W'(0)};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:
          width_r <= (dim == '0) ? WW'(1) :
                     ({21'b0, dim} > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(dim);
        REG_HEIGHT:
          height_r <= (dim == '0) ? HW'(1) :
                      ({21'b0, dim} > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(dim);
        REG_KTOP: krows_r[0] <= cfg_data;
        REG_KMID: krows_r[1] <= cfg_data;
        REG_KBOT: krows_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  c3x3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst_n, .cfg_geom,
    .width(width_r), .height(height_r),
    .in_valid, .in_ready, .in_action, .in_pixel,
    .job_valid, .job_ready, .job
  );

  c3x3_back u_back (
    .clk, .rst_n, .krows(krows_r),
    .job_valid, .job_ready, .job,
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign out_filtered_value = res.value;
  assign out_row            = res.row;
  assign out_col            = res.col;
  assign out_last_of_run    = res.last;
  assign out_end_of_frame   = res.eof;
endmodule
